// ----- sv/ppeq_pkg.sv -----
// Package for the per-process event queue bank: sizes, derived widths,
// item codes and the ring address helpers.
// Depends on nothing; imported by the top level.
`default_nettype none

package ppeq_pkg;

  localparam int QUEUE_COUNT = 32;
  localparam int RING_DEPTH  = 16;

  localparam int KIND_W  = 2;
  localparam int PID_W   = 8;
  localparam int EVENT_W = 64;

  localparam int QIDX_W   = (QUEUE_COUNT > 1) ? $clog2(QUEUE_COUNT) : 1;
  localparam int PTR_W    = $clog2(RING_DEPTH);
  localparam int STORE_DEPTH = QUEUE_COUNT * RING_DEPTH;
  localparam int STORE_AW = $clog2(STORE_DEPTH);

  // Pointer memory word holds the write pointer above the read pointer.
  localparam int PTRS_W = 2 * PTR_W;

  // Configuration port.
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam int REG_IDX_W = PADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_FOCUS_PID = REG_IDX_W'(0);

  typedef enum logic [KIND_W-1:0] {
    KIND_ENQ_PID   = 2'd0,
    KIND_ENQ_FOCUS = 2'd1,
    KIND_DEQ       = 2'd2
  } kind_t;

  typedef struct packed {
    logic [PTR_W-1:0] wp;
    logic [PTR_W-1:0] rp;
  } ptrs_t;

  function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
    logic [PTR_W-1:0] r;
    if (p == PTR_W'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = p + PTR_W'(1);
    end
    return r;
  endfunction

  function automatic logic [STORE_AW-1:0] store_addr(input logic [QIDX_W-1:0] q,
                                                     input logic [PTR_W-1:0]  p);
    logic [STORE_AW-1:0] a;
    a = STORE_AW'(q) * STORE_AW'(RING_DEPTH) + STORE_AW'(p);
    return a;
  endfunction

endpackage

`default_nettype wire

// ----- sv/ppeq_ram.sv -----
// Generic single-clock RAM with one write port and one registered read port.
// Stand-alone; used for the event store and the pointer memory.
`default_nettype none

module ppeq_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                                       clk,
  input  wire logic                                       we,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  wire logic [WIDTH-1:0]                           wdata,
  input  wire logic                                       re,
  input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic      [WIDTH-1:0]                           rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  // A read at the address being written returns the old word.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- sv/per_process_event_queue_bank.sv -----
// Top level of the per-process event queue bank: handshakes, pointer
// read-modify-write with forwarding, and the configuration register.
// Depends on ppeq_pkg and ppeq_ram.
`default_nettype none

// Channel   Direction  Handshake            Payload
// in        input      in_valid / in_stall  in_kind, in_pid, in_event_data
// out       output     out_valid / out_stall out_event_out, out_got_event, out_dropped
// cfg       input      psel/penable/pwrite  paddr, pwdata, prdata (pready tied high)
//
// The bank sustains one transfer per cycle while the output is not stalled; each item's
// result is presented after the registered read of the pointer memory followed by
// the registered read of the event store.
// Reset clears the focus register, the pipeline valids and the pointer valid bits;
// the memories themselves are not cleared, so no clearing pass is needed.
// A stall on the output holds the result in place and backs up into in_stall once
// the middle stage is occupied.

module per_process_event_queue_bank
  import ppeq_pkg::*;
(
  input  wire logic                clk,
  input  wire logic                rst_n,

  input  wire logic                in_valid,
  output logic                     in_stall,
  input  wire logic [KIND_W-1:0]   in_kind,
  input  wire logic [PID_W-1:0]    in_pid,
  input  wire logic [EVENT_W-1:0]  in_event_data,

  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic      [EVENT_W-1:0]  out_event_out,
  output logic                     out_got_event,
  output logic                     out_dropped,

  input  wire logic                psel,
  input  wire logic                penable,
  input  wire logic                pwrite,
  input  wire logic [PADDR_W-1:0]  paddr,
  input  wire logic [PDATA_W-1:0]  pwdata,
  output logic      [PDATA_W-1:0]  prdata,
  output logic                     pready
);

  // Configuration register. The register index sits above the byte offset;
  // a write to any other index is ignored.
  logic [PID_W-1:0] focus_pid_r;
  logic             cfg_wr;
  logic             cfg_hit;

  assign pready  = 1'b1;
  assign cfg_hit = (paddr[PADDR_W-1:2] == REG_FOCUS_PID);
  assign cfg_wr  = psel && penable && pwrite && pready && cfg_hit;
  assign prdata  = cfg_hit ? PDATA_W'(focus_pid_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      focus_pid_r <= '0;
    end else if (cfg_wr) begin
      focus_pid_r <= pwdata[PID_W-1:0];
    end
  end

  // Pipeline control. Stage one holds the item while its pointers are read;
  // the output stage holds the result, with the event word kept in the store's
  // read register.
  logic s1_valid_r;
  logic out_valid_r;
  logic out_adv;
  logic s1_go;
  logic in_acc;

  assign out_adv  = !out_valid_r || !out_stall;
  assign s1_go    = s1_valid_r && out_adv;
  assign in_stall = s1_valid_r && !out_adv;
  assign in_acc   = in_valid && !in_stall;

  // Accept: resolve the target pid and start the pointer read.
  logic [PID_W-1:0]  tgt_pid;
  logic              tgt_ok;
  logic [QIDX_W-1:0] tgt_q;

  always_comb begin
    if (in_kind == KIND_ENQ_FOCUS) begin
      tgt_pid = focus_pid_r;
    end else begin
      tgt_pid = in_pid;
    end
    tgt_ok = (tgt_pid != '0) && (32'(tgt_pid) <= QUEUE_COUNT);
    // An invalid pid still indexes a real queue so the valid bit lookup stays
    // in range; its pointers are never used.
    tgt_q  = tgt_ok ? QIDX_W'(tgt_pid - PID_W'(1)) : '0;
  end

  logic [KIND_W-1:0]    s1_kind_r;
  logic [QIDX_W-1:0]    s1_q_r;
  logic                 s1_ok_r;
  logic [EVENT_W-1:0]   s1_data_r;
  logic                 s1_pvld_r;
  logic [QUEUE_COUNT-1:0] ptr_vld_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_acc) begin
      s1_valid_r <= 1'b1;
    end else if (s1_go) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_kind_r <= in_kind;
      s1_q_r    <= tgt_q;
      s1_ok_r   <= tgt_ok;
      s1_data_r <= in_event_data;
      // Sampled with the memory read, so both see the state before this edge.
      s1_pvld_r <= ptr_vld_r[tgt_q];
    end
  end

  // Pointer memory and the forwarding register. The forwarding register holds
  // the most recent pointer write, which covers a read that raced that write.
  ptrs_t             ptr_rdata;
  ptrs_t             ptr_wdata;
  logic              ptr_we;
  logic              fwd_valid_r;
  logic [QIDX_W-1:0] fwd_q_r;
  ptrs_t             fwd_ptrs_r;
  ptrs_t             cur;

  ppeq_ram #(
    .WIDTH (PTRS_W),
    .DEPTH (QUEUE_COUNT)
  ) u_ptr_ram (
    .clk   (clk),
    .we    (ptr_we),
    .waddr (s1_q_r),
    .wdata (ptr_wdata),
    .re    (in_acc),
    .raddr (tgt_q),
    .rdata (ptr_rdata)
  );

  always_comb begin
    if (fwd_valid_r && (fwd_q_r == s1_q_r)) begin
      cur = fwd_ptrs_r;
    end else if (s1_pvld_r) begin
      cur = ptr_rdata;
    end else begin
      cur = '0;
    end
  end

  // Ring decision for the item in stage one.
  logic               st_we;
  logic               st_re;
  logic [STORE_AW-1:0] st_waddr;
  logic [STORE_AW-1:0] st_raddr;
  logic               res_got;
  logic               res_drop;
  logic [PTR_W-1:0]   wp_nxt;

  always_comb begin
    ptr_we    = 1'b0;
    ptr_wdata = cur;
    st_we     = 1'b0;
    st_re     = 1'b0;
    res_got   = 1'b0;
    res_drop  = 1'b0;
    wp_nxt    = ptr_inc(cur.wp);
    st_waddr  = store_addr(s1_q_r, cur.wp);
    st_raddr  = store_addr(s1_q_r, cur.rp);
    unique case (kind_t'(s1_kind_r))
      KIND_ENQ_PID, KIND_ENQ_FOCUS: begin
        if (!s1_ok_r || (wp_nxt == cur.rp)) begin
          res_drop = 1'b1;
        end else begin
          st_we        = s1_go;
          ptr_we       = s1_go;
          ptr_wdata.wp = wp_nxt;
        end
      end
      KIND_DEQ: begin
        if (s1_ok_r && (cur.rp != cur.wp)) begin
          res_got      = 1'b1;
          st_re        = s1_go;
          ptr_we       = s1_go;
          ptr_wdata.rp = ptr_inc(cur.rp);
        end
      end
      default: begin
        // The unused code changes nothing and answers all zero.
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fwd_valid_r <= 1'b0;
      ptr_vld_r   <= '0;
    end else if (ptr_we) begin
      fwd_valid_r       <= 1'b1;
      ptr_vld_r[s1_q_r] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (ptr_we) begin
      fwd_q_r    <= s1_q_r;
      fwd_ptrs_r <= ptr_wdata;
    end
  end

  // Event store. Its read register doubles as the output event word and holds
  // while the output is stalled, since no new read starts until it moves.
  logic [EVENT_W-1:0] st_rdata;

  ppeq_ram #(
    .WIDTH (EVENT_W),
    .DEPTH (STORE_DEPTH)
  ) u_event_ram (
    .clk   (clk),
    .we    (st_we),
    .waddr (st_waddr),
    .wdata (s1_data_r),
    .re    (st_re),
    .raddr (st_raddr),
    .rdata (st_rdata)
  );

  // Output stage.
  logic out_got_r;
  logic out_drop_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_got_r  <= res_got;
      out_drop_r <= res_drop;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_got_event = out_got_r;
  assign out_dropped   = out_drop_r;
  assign out_event_out = out_got_r ? st_rdata : '0;

endmodule

`default_nettype wire

// ----- tb/sv/per_process_event_queue_bank_tb.sv -----
// Self-checking testbench for the per-process event queue bank: directed and random
// transfers checked against a behavioural copy of the queues and the focus register.
// Depends on ppeq_pkg and the per_process_event_queue_bank RTL.
`timescale 1ns / 100ps

module per_process_event_queue_bank_tb;
  import ppeq_pkg::*;

  // Kind 3 has no meaning in the block; it must leave every queue untouched.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam logic [PADDR_W-1:0] FOCUS_ADDR = PADDR_W'({REG_FOCUS_PID, 2'b00});
  localparam int MAX_WAIT = 12;
  // Extra settling after the last result leaves, as a little margin.
  localparam int DRAIN_CYCLES = 6;
  localparam int RANDOM_PHASES = 12;
  localparam int PHASE_ITEMS = 120;

  // One result of the block, in the order of its output fields.
  typedef struct packed {
    logic [EVENT_W-1:0] event_word;
    logic               got;
    logic               drop;
  } queue_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;

  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [KIND_W-1:0]  in_kind = '0;
  logic [PID_W-1:0]   in_pid = '0;
  logic [EVENT_W-1:0] in_event_data = '0;

  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [EVENT_W-1:0] out_event_out;
  logic               out_got_event;
  logic               out_dropped;

  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [PADDR_W-1:0] paddr = '0;
  logic [PDATA_W-1:0] pwdata = '0;
  logic [PDATA_W-1:0] prdata;
  logic               pready;

  // Behavioural copy of the bank: the event words of every ring, the write and read
  // indexes of each queue, and the focus register.
  logic [EVENT_W-1:0] ring_words [QUEUE_COUNT][RING_DEPTH];
  int unsigned        wr_index [QUEUE_COUNT];
  int unsigned        rd_index [QUEUE_COUNT];
  logic [PID_W-1:0]   focus_reg = '0;

  // Results still owed by the block, oldest first.
  queue_result_t      owed_results [$];

  // Idling controls: each side may draw a random wait bounded by MAX_WAIT per transfer,
  // and the receiver can be held off entirely for the back-pressure test.
  bit                 sender_idles = 1'b0;
  bit                 receiver_idles = 1'b0;
  logic               hold_off = 1'b0;
  int                 stall_left = 0;

  int                 mismatch_count = 0;
  int                 stored_count = 0;
  int                 dropped_count = 0;
  int                 delivered_count = 0;
  int                 idle_count = 0;
  int                 focus_writes = 0;

  per_process_event_queue_bank uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_kind       (in_kind),
    .in_pid        (in_pid),
    .in_event_data (in_event_data),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_event_out (out_event_out),
    .out_got_event (out_got_event),
    .out_dropped   (out_dropped),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  function automatic bit pid_ok(input int unsigned p);
    return (p >= 1) && (p <= QUEUE_COUNT);
  endfunction

  // Stores a word in the queue of pid p; fails for an invalid pid or a full ring,
  // which keeps one slot free so that full and empty can be told apart.
  function automatic bit push_word(input int unsigned p, input logic [EVENT_W-1:0] w);
    int unsigned q;
    int unsigned nxt;
    if (!pid_ok(p)) return 1'b0;
    q = p - 1;
    nxt = (wr_index[q] + 1) % RING_DEPTH;
    if (nxt == rd_index[q]) return 1'b0;
    ring_words[q][wr_index[q]] = w;
    wr_index[q] = nxt;
    return 1'b1;
  endfunction

  // Applies one accepted transfer to the copy of the bank and returns what the
  // block must answer for it.
  function automatic queue_result_t predict_transfer(input logic [KIND_W-1:0] kind,
                                                     input logic [PID_W-1:0] pid,
                                                     input logic [EVENT_W-1:0] w);
    queue_result_t r;
    int unsigned   q;
    r = '0;
    case (kind)
      KIND_ENQ_PID: begin
        r.drop = !push_word(pid, w);
      end
      KIND_ENQ_FOCUS: begin
        r.drop = !push_word(focus_reg, w);
      end
      KIND_DEQ: begin
        if (pid_ok(pid)) begin
          q = pid - 1;
          if (rd_index[q] != wr_index[q]) begin
            r.event_word = ring_words[q][rd_index[q]];
            r.got = 1'b1;
            rd_index[q] = (rd_index[q] + 1) % RING_DEPTH;
          end
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic note_mismatch(input string what, input logic [EVENT_W-1:0] want,
                               input logic [EVENT_W-1:0] seen);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("%0t: %s mismatch: expected %h, got %h", $realtime, what, want, seen);
    end
  endtask

  // Every result transfer is compared with the oldest result still owed.
  always @(posedge clk) begin : check_results
    queue_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (owed_results.size() == 0) begin
        note_mismatch("unexpected result", '0, out_event_out);
      end else begin
        want = owed_results.pop_front();
        if (out_event_out !== want.event_word) begin
          note_mismatch("event_out", want.event_word, out_event_out);
        end
        if (out_got_event !== want.got) begin
          note_mismatch("got_event", want.got, out_got_event);
        end
        if (out_dropped !== want.drop) begin
          note_mismatch("dropped", want.drop, out_dropped);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver: if receiver_idles is set, each result transfer may draw a stall bounded
  // by MAX_WAIT. While hold_off is high it refuses everything, whatever is pending.
  // ---------------------------------------------------------------------------

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (hold_off) begin
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      out_stall <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if (out_valid && !out_stall && receiver_idles) begin
        stall_left <= $urandom_range(0, MAX_WAIT);
      end
    end
  end

  // Counts out a long hold-off in its own process so that the sender can keep
  // offering transfers meanwhile.
  task automatic hold_receiver(input int cycles);
    hold_off <= 1'b1;
    repeat (cycles) @(posedge clk);
    hold_off <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // Sender and configuration port
  // ---------------------------------------------------------------------------

  // Offers one item after a drawn gap and returns at the edge where it is taken.
  // Valid is left high, so that a following item can go out without a gap; whoever
  // comes next lowers it if needed.
  task automatic send_item(input logic [KIND_W-1:0] kind, input logic [PID_W-1:0] pid,
                           input logic [EVENT_W-1:0] w);
    int            gap;
    queue_result_t r;
    gap = sender_idles ? $urandom_range(0, MAX_WAIT) : 0;
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind <= kind;
    in_pid <= pid;
    in_event_data <= w;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    r = predict_transfer(kind, pid, w);
    owed_results.push_back(r);
    if (r.drop) dropped_count++;
    else if (r.got) delivered_count++;
    else if (kind == KIND_ENQ_PID || kind == KIND_ENQ_FOCUS) stored_count++;
    else idle_count++;
  endtask

  // Lowers valid, waits for every owed result and lets the pipeline settle.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes the focus register (with junk in the unused upper bits) and reads it back.
  // Only called while the bank is idle.
  task automatic set_focus(input logic [PID_W-1:0] f);
    logic [PDATA_W-1:0] bus_word;
    bus_word = $urandom();
    bus_word[PID_W-1:0] = f;
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= FOCUS_ADDR;
    pwdata <= bus_word;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    focus_reg = f;
    focus_writes++;
    // Read back: setup, then access; prdata is taken at the completing edge.
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    if (prdata[PID_W-1:0] !== focus_reg) begin
      note_mismatch("focus_pid read-back", focus_reg, prdata[PID_W-1:0]);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [EVENT_W-1:0] random_word();
    return {$urandom(), $urandom()};
  endfunction

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Pids outside 1..QUEUE_COUNT, an empty queue, the unused kind and a focused
  // enqueue while no focus is set (the reset value).
  task automatic test_invalid_targets();
    send_item(KIND_ENQ_PID, 8'd0, '1);
    send_item(KIND_ENQ_PID, PID_W'(QUEUE_COUNT + 1), random_word());
    send_item(KIND_ENQ_PID, 8'd255, random_word());
    send_item(KIND_DEQ, 8'd0, random_word());
    send_item(KIND_DEQ, PID_W'(QUEUE_COUNT + 1), '1);
    send_item(KIND_DEQ, 8'd255, random_word());
    send_item(KIND_DEQ, 8'd1, random_word());
    send_item(KIND_UNUSED, 8'd1, random_word());
    send_item(KIND_ENQ_FOCUS, 8'd1, random_word());
  endtask

  // All-zero, all-one and alternating words through the first and last queue.
  task automatic test_word_extremes();
    send_item(KIND_ENQ_PID, 8'd1, '1);
    send_item(KIND_ENQ_PID, PID_W'(QUEUE_COUNT), '0);
    send_item(KIND_ENQ_PID, PID_W'(QUEUE_COUNT), {32{2'b10}});
    send_item(KIND_DEQ, PID_W'(QUEUE_COUNT), '0);
    send_item(KIND_DEQ, PID_W'(QUEUE_COUNT), '1);
    send_item(KIND_DEQ, 8'd1, {32{2'b01}});
    send_item(KIND_DEQ, 8'd1, '0);
  endtask

  // Focused enqueues to the last and first queue, and to pids the bank does not have.
  task automatic test_focus_routing();
    wait_idle();
    set_focus(PID_W'(QUEUE_COUNT));
    send_item(KIND_ENQ_FOCUS, 8'd0, random_word());
    send_item(KIND_DEQ, PID_W'(QUEUE_COUNT), random_word());
    wait_idle();
    set_focus(8'd1);
    send_item(KIND_ENQ_FOCUS, 8'd255, random_word());
    send_item(KIND_DEQ, 8'd1, random_word());
    wait_idle();
    set_focus(PID_W'(QUEUE_COUNT + 1));
    send_item(KIND_ENQ_FOCUS, 8'd1, random_word());
    wait_idle();
    set_focus(8'd255);
    send_item(KIND_ENQ_FOCUS, 8'd1, random_word());
  endtask

  // Fills one queue to capacity, overflows it directly and through the focus,
  // then drains it past empty.
  task automatic test_queue_full();
    logic [PID_W-1:0] target;
    target = PID_W'($urandom_range(2, QUEUE_COUNT - 1));
    wait_idle();
    set_focus(target);
    repeat (RING_DEPTH) send_item(KIND_ENQ_PID, target, random_word());
    send_item(KIND_ENQ_FOCUS, 8'd0, random_word());
    repeat (RING_DEPTH) send_item(KIND_DEQ, target, random_word());
  endtask

  // The receiver refuses results for a long stretch while the sender keeps going,
  // so the bank fills up and stalls its input; then everything drains.
  task automatic test_backpressure();
    logic [PID_W-1:0] target;
    wait_idle();
    sender_idles = 1'b0;
    receiver_idles = 1'b0;
    target = PID_W'($urandom_range(1, QUEUE_COUNT));
    fork
      hold_receiver(250);
    join_none
    for (int i = 0; i < 60; i++) begin
      send_item((i % 3 == 2) ? KIND_DEQ : KIND_ENQ_PID, target, random_word());
    end
  endtask

  // Phases of random traffic. Each phase sets a new focus and concentrates on a few
  // pids, so queues really fill and empty; the bias of the phase leans towards
  // filling, draining or a balance. A small share is noise over the whole pid range.
  task automatic test_random_traffic();
    logic [PID_W-1:0]  hot [3];
    logic [PID_W-1:0]  f;
    logic [KIND_W-1:0] kind;
    logic [PID_W-1:0]  pid;
    int                enq_pct;
    int                focus_pct;
    int                roll;
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      wait_idle();
      case ($urandom_range(0, 7))
        0: f = 8'd0;
        1: f = 8'd255;
        2: f = PID_W'(QUEUE_COUNT + 1);
        3: f = PID_W'(QUEUE_COUNT);
        4: f = 8'd1;
        default: f = PID_W'($urandom_range(1, QUEUE_COUNT));
      endcase
      set_focus(f);
      sender_idles = (phase % 4 == 1) || (phase % 4 == 3);
      receiver_idles = (phase % 4 == 2) || (phase % 4 == 3);
      hot[0] = pid_ok(f) ? f : PID_W'($urandom_range(1, QUEUE_COUNT));
      hot[1] = PID_W'($urandom_range(1, QUEUE_COUNT));
      hot[2] = ($urandom_range(0, 1) == 0) ? PID_W'(QUEUE_COUNT) : 8'd1;
      case (phase % 3)
        0: begin enq_pct = 35; focus_pct = 10; end
        1: begin enq_pct = 60; focus_pct = 20; end
        default: begin enq_pct = 20; focus_pct = 5; end
      endcase
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        roll = $urandom_range(0, 99);
        pid = hot[$urandom_range(0, 2)];
        if (roll < 5) begin
          kind = KIND_W'($urandom_range(0, 3));
          pid = PID_W'($urandom_range(0, 255));
        end else if (roll < 5 + enq_pct) begin
          kind = KIND_ENQ_PID;
        end else if (roll < 5 + enq_pct + focus_pct) begin
          kind = KIND_ENQ_FOCUS;
          pid = PID_W'($urandom_range(0, 255));
        end else begin
          kind = KIND_DEQ;
        end
        send_item(kind, pid, random_word());
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------

  initial begin
    for (int q = 0; q < QUEUE_COUNT; q++) begin
      wr_index[q] = 0;
      rd_index[q] = 0;
    end
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    sender_idles = 1'b1;
    receiver_idles = 1'b1;
    test_invalid_targets();
    test_word_extremes();
    test_focus_routing();
    test_queue_full();
    test_backpressure();
    test_random_traffic();

    wait_idle();
    $display("Run covered %0d transfers: %0d stored, %0d dropped, %0d dequeued, %0d empty.",
             stored_count + dropped_count + delivered_count + idle_count, stored_count,
             dropped_count, delivered_count, idle_count);
    $display("Focus register written %0d times; %0d mismatches seen.",
             focus_writes, mismatch_count);
    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

  // Guard against a hung handshake: far beyond the slowest correct run.
  initial begin
    #5_000_000;
    $display("Timeout with %0d results still owed.", owed_results.size());
    $display("Some tests failed");
    $finish;
  end

endmodule
